### hw/rtl/tmr_pkg.sv
// shared constants, types and codes for the tile map pixel renderer
`timescale 1ns / 1ps

package tmr_pkg;

    // map geometry in tiles
    localparam int MAP_COLS        = 128;
    localparam int MAP_ROWS        = 64;
    localparam int TILE_SIZE       = 8;
    localparam int PALETTE_ENTRIES = 16;

    // sprite sheet geometry in pixels
    localparam int SHEET_DIM     = 128;
    localparam int CELLS_PER_ROW = 16;

    localparam int MAP_DEPTH   = MAP_COLS * MAP_ROWS;
    localparam int SHEET_DEPTH = SHEET_DIM * SHEET_DIM;
    localparam int CLR_DEPTH   = (MAP_DEPTH > SHEET_DEPTH) ? MAP_DEPTH : SHEET_DEPTH;

    localparam int MAP_AW   = $clog2(MAP_DEPTH);
    localparam int SHEET_AW = $clog2(SHEET_DEPTH);
    localparam int SHEET_DW = $clog2(SHEET_DIM);
    localparam int PAL_AW   = $clog2(PALETTE_ENTRIES);
    localparam int CLR_W    = $clog2(CLR_DEPTH);
    localparam int TILE_W   = $clog2(TILE_SIZE);
    localparam int CELL_W   = $clog2(CELLS_PER_ROW);

    localparam int SPR_W   = 8;
    localparam int INDEX_W = 4;
    localparam int COLOR_W = 16;
    localparam int CHAN_W  = 8;

    localparam int COL_W = 10;
    localparam int ROW_W = 9;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hff;

    typedef enum logic [1:0] {
        CMD_MAP_WR   = 2'd0,
        CMD_SHEET_WR = 2'd1,
        CMD_PAL_WR   = 2'd2,
        CMD_FETCH    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP,
        ST_SHEET,
        ST_PAL
    } t_state;

endpackage

### hw/rtl/tmr_ram.sv
// generic simple dual-port ram, one write and one registered read port
`timescale 1ns / 1ps

module tmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/tile_map_pixel_renderer.sv
// tile map pixel renderer: map, sprite sheet and palette rams with fetch sequencer
//
//  channel   | handshake              | words
//  ----------+------------------------+------------------------------------
//  command   | start high, busy low   | i_command, i_col, i_row, i_value
//  result    | o_strobe, one cycle    | o_red, o_green, o_blue, o_alpha
//
// a write command is taken while idle; busy stays low after it.
// a fetch does a map read, a sheet read and a palette read in turn, then puts the
// result word on o_strobe; the three ram reads are chained one after another.
// after reset the map and sheet are zeroed one entry per cycle, in
// parallel, with busy high until the larger of the two rams is cleared.
// the receiver cannot stall; each result shows for exactly one cycle.
`timescale 1ns / 1ps

module tile_map_pixel_renderer
    import tmr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_command,
    input  logic [COL_W-1:0]  i_col,
    input  logic [ROW_W-1:0]  i_row,
    input  logic [15:0]       i_value,
    output logic              o_strobe,
    output logic [CHAN_W-1:0] o_red,
    output logic [CHAN_W-1:0] o_green,
    output logic [CHAN_W-1:0] o_blue,
    output logic [CHAN_W-1:0] o_alpha
);

    t_state             r_state, n_state;
    logic [CLR_W-1:0]   r_clr_cnt, n_clr_cnt;
    logic [TILE_W-1:0]  r_px_lo, n_px_lo;
    logic [TILE_W-1:0]  r_py_lo, n_py_lo;
    logic               r_oob, n_oob;
    logic               r_blank, n_blank;

    logic                map_we;
    logic [MAP_AW-1:0]   map_waddr;
    logic [SPR_W-1:0]    map_wdata;
    logic [MAP_AW-1:0]   map_raddr;
    logic [SPR_W-1:0]    map_rdata;

    logic                sheet_we;
    logic [SHEET_AW-1:0] sheet_waddr;
    logic [INDEX_W-1:0]  sheet_wdata;
    logic [SHEET_AW-1:0] sheet_raddr;
    logic [INDEX_W-1:0]  sheet_rdata;

    logic                pal_we;
    logic [PAL_AW-1:0]   pal_waddr;
    logic [PAL_AW-1:0]   pal_raddr;
    logic [COLOR_W-1:0]  pal_rdata;

    logic                accept;
    t_cmd                cmd;
    logic [COL_W-TILE_W-1:0] tile_x;
    logic [ROW_W-TILE_W-1:0] tile_y;
    logic [SPR_W-1:0]    sprite;
    logic [INDEX_W-1:0]  pal_idx;

    tmr_ram #(.WIDTH(SPR_W), .DEPTH(MAP_DEPTH)) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    tmr_ram #(.WIDTH(INDEX_W), .DEPTH(SHEET_DEPTH)) u_sheet_ram (
        .i_clk   (i_clk),
        .i_we    (sheet_we),
        .i_waddr (sheet_waddr),
        .i_wdata (sheet_wdata),
        .i_raddr (sheet_raddr),
        .o_rdata (sheet_rdata)
    );

    tmr_ram #(.WIDTH(COLOR_W), .DEPTH(PALETTE_ENTRIES)) u_pal_ram (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (pal_waddr),
        .i_wdata (i_value),
        .i_raddr (pal_raddr),
        .o_rdata (pal_rdata)
    );

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign cmd    = t_cmd'(i_command);
    assign tile_x = i_col[COL_W-1:TILE_W];
    assign tile_y = i_row[ROW_W-1:TILE_W];

    // sprite 0 and pixels outside the map fall back to palette entry 0
    assign sprite    = r_oob ? '0 : map_rdata;
    assign pal_idx   = r_blank ? '0 : sheet_rdata;
    assign pal_raddr = pal_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
        end
        r_px_lo <= n_px_lo;
        r_py_lo <= n_py_lo;
        r_oob   <= n_oob;
        r_blank <= n_blank;
    end

    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        n_px_lo   = r_px_lo;
        n_py_lo   = r_py_lo;
        n_oob     = r_oob;
        n_blank   = r_blank;

        map_we      = 1'b0;
        map_waddr   = MAP_AW'(32'(i_row) * MAP_COLS + 32'(i_col));
        map_wdata   = i_value[SPR_W-1:0];
        map_raddr   = MAP_AW'(32'(tile_y) * MAP_COLS + 32'(tile_x));
        sheet_we    = 1'b0;
        sheet_waddr = {i_row[SHEET_DW-1:0], i_col[SHEET_DW-1:0]};
        sheet_wdata = i_value[INDEX_W-1:0];
        sheet_raddr = {sprite[SPR_W-1:CELL_W], r_py_lo, sprite[CELL_W-1:0], r_px_lo};
        pal_we      = 1'b0;
        pal_waddr   = i_col[PAL_AW-1:0];
        o_strobe    = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                map_waddr   = r_clr_cnt[MAP_AW-1:0];
                map_wdata   = '0;
                map_we      = (32'(r_clr_cnt) < MAP_DEPTH);
                sheet_waddr = r_clr_cnt[SHEET_AW-1:0];
                sheet_wdata = '0;
                sheet_we    = (32'(r_clr_cnt) < SHEET_DEPTH);
                n_clr_cnt   = r_clr_cnt + 1'b1;
                if (32'(r_clr_cnt) == CLR_DEPTH - 1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (cmd)
                        CMD_MAP_WR: begin
                            map_we = (32'(i_col) < MAP_COLS) && (32'(i_row) < MAP_ROWS);
                        end
                        CMD_SHEET_WR: begin
                            sheet_we = (32'(i_col) < SHEET_DIM) && (32'(i_row) < SHEET_DIM);
                        end
                        CMD_PAL_WR: begin
                            pal_we = (32'(i_col) < PALETTE_ENTRIES);
                        end
                        CMD_FETCH: begin
                            n_px_lo = i_col[TILE_W-1:0];
                            n_py_lo = i_row[TILE_W-1:0];
                            n_oob   = (32'(tile_x) >= MAP_COLS) || (32'(tile_y) >= MAP_ROWS);
                            n_state = ST_MAP;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MAP: begin
                // map word is back, sheet read issues this cycle
                n_blank = (sprite == '0);
                n_state = ST_SHEET;
            end
            ST_SHEET: begin
                n_state = ST_PAL;
            end
            ST_PAL: begin
                o_strobe = 1'b1;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_red   = {pal_rdata[15:11], 3'b000};
    assign o_green = {pal_rdata[10:5], 2'b00};
    assign o_blue  = {pal_rdata[4:0], 3'b000};
    assign o_alpha = ALPHA_OPAQUE;

endmodule
